### design/tvsf_pkg.sv
package tvsf_pkg;

	localparam logic [7:0] HDR_BYTE = 8'h5E;
	localparam logic [7:0] ESC_BYTE = 8'h5D;
	localparam logic [7:0] ESC_FLIP = 8'h60;

	localparam logic ACT_VALUE = 1'b0;
	localparam logic ACT_STOP  = 1'b1;

	typedef struct packed {
		logic       is_stop;
		logic [7:0] id;
		logic       lo_esc;
		logic [7:0] lo_tx;
		logic       hi_esc;
		logic [7:0] hi_tx;
	} desc_t;

	typedef enum logic [2:0] {
		ST_HDR,
		ST_ID,
		ST_LO_ESC,
		ST_LO,
		ST_HI_ESC,
		ST_HI
	} step_t;

endpackage

### design/tvsf_in_if.sv
interface tvsf_in_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic [7:0]  value_id;
	logic [15:0] data_word;

	modport source (output valid, output action, output value_id, output data_word,
		input ready);
	modport sink (input valid, input action, input value_id, input data_word,
		output ready);
endinterface

### design/tvsf_out_if.sv
interface tvsf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_of_item;
	logic       frame_end;

	modport source (output valid, output out_byte, output last_of_item, output frame_end,
		input ready);
	modport sink (input valid, input out_byte, input last_of_item, input frame_end,
		output ready);
endinterface

### design/tvsf_front.sv
module tvsf_front
	import tvsf_pkg::*;
(
	tvsf_in_if.sink item,
	input  logic    full,
	output logic    push,
	output desc_t   desc
);

	logic [7:0] lo;
	logic [7:0] hi;

	assign lo = item.data_word[7:0];
	assign hi = item.data_word[15:8];

	assign item.ready = !full;
	assign push       = item.valid && !full;

	always_comb begin
		desc.is_stop = (item.action == ACT_STOP);
		desc.id      = item.value_id;
		desc.lo_esc  = (lo == HDR_BYTE) || (lo == ESC_BYTE);
		desc.hi_esc  = (hi == HDR_BYTE) || (hi == ESC_BYTE);
		desc.lo_tx   = desc.lo_esc ? (lo ^ ESC_FLIP) : lo;
		desc.hi_tx   = desc.hi_esc ? (hi ^ ESC_FLIP) : hi;
	end

endmodule

### design/tvsf_queue.sv
module tvsf_queue
	import tvsf_pkg::*;
#(
	parameter int QDEPTH = 4
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  desc_t wdata,
	output logic  full,
	input  logic  pop,
	output logic  nonempty,
	output desc_t head
);

	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CW = $clog2(QDEPTH + 1);
	localparam logic [PW-1:0] LAST_IDX = PW'(QDEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(QDEPTH);

	desc_t         mem_q [QDEPTH];
	logic [PW-1:0] wptr_q;
	logic [PW-1:0] rptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_pop;

	assign full     = (cnt_q == FULL_CNT);
	assign nonempty = (cnt_q != '0);
	assign head     = mem_q[rptr_q];
	assign do_pop   = pop && nonempty;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == LAST_IDX) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == LAST_IDX) ? '0 : rptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

### design/tvsf_back.sv
module tvsf_back
	import tvsf_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     nonempty,
	input  desc_t    head,
	output logic     pop,
	tvsf_out_if.source stream
);

	step_t      state_q;
	step_t      state_d;
	logic       adv;
	logic [7:0] byte_d;
	logic       last_d;
	logic       fe_d;

	logic       vld_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic       fe_q;

	assign adv = nonempty && (!vld_q || stream.ready);
	assign pop = adv && last_d;

	always_comb begin
		state_d = state_q;
		byte_d  = HDR_BYTE;
		last_d  = 1'b0;
		fe_d    = 1'b0;
		unique case (state_q)
			ST_HDR: begin
				byte_d  = HDR_BYTE;
				last_d  = head.is_stop;
				fe_d    = head.is_stop;
				state_d = head.is_stop ? ST_HDR : ST_ID;
			end
			ST_ID: begin
				byte_d  = head.id;
				state_d = head.lo_esc ? ST_LO_ESC : ST_LO;
			end
			ST_LO_ESC: begin
				byte_d  = ESC_BYTE;
				state_d = ST_LO;
			end
			ST_LO: begin
				byte_d  = head.lo_tx;
				state_d = head.hi_esc ? ST_HI_ESC : ST_HI;
			end
			ST_HI_ESC: begin
				byte_d  = ESC_BYTE;
				state_d = ST_HI;
			end
			ST_HI: begin
				byte_d  = head.hi_tx;
				last_d  = 1'b1;
				state_d = ST_HDR;
			end
			default: begin
				state_d = ST_HDR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HDR;
			vld_q   <= 1'b0;
		end else begin
			if (adv) begin
				state_q <= state_d;
				vld_q   <= 1'b1;
			end else if (stream.ready) begin
				vld_q   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			byte_q <= byte_d;
			last_q <= last_d;
			fe_q   <= fe_d;
		end
	end

	assign stream.valid        = vld_q;
	assign stream.out_byte     = byte_q;
	assign stream.last_of_item = last_q;
	assign stream.frame_end    = fe_q;

	a_fe_is_stop: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q && fe_q |-> last_q && (byte_q == HDR_BYTE))
		else $error("frame end byte malformed");

	a_item_held: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_HDR |-> nonempty)
		else $error("item in progress left the queue");

	a_esc_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LO_ESC) |-> head.lo_esc && !head.is_stop)
		else $error("escape step without escaped low byte");

	a_esc_emit: assert property (@(posedge clk) disable iff (!arst_n)
		adv && ((state_q == ST_LO_ESC) || (state_q == ST_HI_ESC)) |=>
		vld_q && (byte_q == ESC_BYTE) && !last_q)
		else $error("escape byte not emitted");

endmodule

### design/telemetry_value_stuffing_framer.sv
// Telemetry byte-stuffing framer. Each accepted item becomes one to six stream
// bytes: a value record gives header 0x5E, the id, then low and high data bytes,
// each data byte equal to 0x5E or 0x5D sent as 0x5D and the byte XOR 0x60; a
// stop item gives a single 0x5E flagged frame_end. The stream side emits one
// byte per cycle while ready is held high, and that byte sequencer sets the
// sustained rate. Items are classified on entry and held in a QDEPTH-entry
// queue, so input transfers continue, until the queue is full, while earlier
// bytes are still draining or stalled. No state is kept between items.
module telemetry_value_stuffing_framer
	import tvsf_pkg::*;
#(
	parameter int QDEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	tvsf_in_if.sink    item,
	tvsf_out_if.source stream
);

	desc_t desc;
	desc_t head;
	logic  push;
	logic  full;
	logic  pop;
	logic  nonempty;

	tvsf_front u_front (
		.item (item),
		.full (full),
		.push (push),
		.desc (desc)
	);

	tvsf_queue #(
		.QDEPTH (QDEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wdata    (desc),
		.full     (full),
		.pop      (pop),
		.nonempty (nonempty),
		.head     (head)
	);

	tvsf_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.nonempty (nonempty),
		.head     (head),
		.pop      (pop),
		.stream   (stream)
	);

endmodule

### tb/tvsf_tb_pkg.sv
package tvsf_tb_pkg;
	import tvsf_pkg::*;

	typedef struct packed {
		logic [7:0] value;
		logic       last;
		logic       fe;
	} stream_byte_t;

	class stuffed_stream_model;
		stream_byte_t pending_bytes[$];
		int           mismatches = 0;

		function void push_byte(logic [7:0] value);
			stream_byte_t entry;
			entry.value = value;
			entry.last  = 1'b0;
			entry.fe    = 1'b0;
			pending_bytes.push_back(entry);
		endfunction

		function void push_data_byte(logic [7:0] value);
			if (value == HDR_BYTE || value == ESC_BYTE) begin
				push_byte(ESC_BYTE);
				push_byte(value ^ ESC_FLIP);
			end else begin
				push_byte(value);
			end
		endfunction

		function void mark_last(logic fe);
			stream_byte_t entry;
			entry      = pending_bytes.pop_back();
			entry.last = 1'b1;
			entry.fe   = fe;
			pending_bytes.push_back(entry);
		endfunction

		function void add_item(logic action, logic [7:0] id, logic [15:0] word);
			push_byte(HDR_BYTE);
			if (action == ACT_STOP) begin
				mark_last(1'b1);
			end else begin
				push_byte(id);
				push_data_byte(word[7:0]);
				push_data_byte(word[15:8]);
				mark_last(1'b0);
			end
		endfunction

		function int pending();
			return pending_bytes.size();
		endfunction

		task flag_mismatch(string msg);
			$display("mismatch: %s", msg);
			mismatches++;
		endtask

		task check_byte(logic [7:0] value, logic last, logic fe);
			stream_byte_t want;
			if (pending_bytes.size() == 0) begin
				flag_mismatch($sformatf("unexpected byte %02h last %b fe %b", value, last, fe));
				return;
			end
			want = pending_bytes.pop_front();
			if (value !== want.value)
				flag_mismatch($sformatf("out_byte %02h, want %02h", value, want.value));
			if (last !== want.last)
				flag_mismatch($sformatf("last_of_item %b, want %b (byte %02h)", last, want.last,
					want.value));
			if (fe !== want.fe)
				flag_mismatch($sformatf("frame_end %b, want %b (byte %02h)", fe, want.fe,
					want.value));
		endtask
	endclass

endpackage

### tb/telemetry_value_stuffing_framer_tb.sv
module telemetry_value_stuffing_framer_tb;
	import tvsf_pkg::*;
	import tvsf_tb_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_ITEMS = 200;
	localparam int HOLD_AT      = 60;
	localparam int HOLD_CYCLES  = 100;
	localparam int QUIET_AT     = 200;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	tvsf_in_if  in_ch ();
	tvsf_out_if out_ch ();

	telemetry_value_stuffing_framer u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (in_ch),
		.stream (out_ch)
	);

	stuffed_stream_model stream_model = new;

	int items_sent = 0;
	bit hold       = 1'b0;
	bit quiet      = 1'b0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task send_item(logic action, logic [7:0] id, logic [15:0] word);
		int gap;
		gap = 0;
		if (!quiet && !hold && $urandom_range(0, 3) == 0)
			gap = $urandom_range(1, 10);
		@(negedge clk);
		if (gap > 0) begin
			in_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid     = 1'b1;
		in_ch.action    = action;
		in_ch.value_id  = id;
		in_ch.data_word = word;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		stream_model.add_item(action, id, word);
		items_sent++;
		if (items_sent >= QUIET_AT)
			quiet = 1'b1;
	endtask

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 5))
			0: return HDR_BYTE;
			1: return ESC_BYTE;
			2: return HDR_BYTE ^ ESC_FLIP;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// receiver with random stall bursts
	initial begin
		int stall;
		stall = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall > 0)
				stall--;
			else if (!quiet && $urandom_range(0, 7) == 0)
				stall = $urandom_range(1, 10);
			out_ch.ready = !hold && stall == 0;
		end
	end

	// long receiver hold-off so the input side backs up
	initial begin
		wait (items_sent >= HOLD_AT);
		@(negedge clk);
		hold = 1'b1;
		repeat (HOLD_CYCLES) @(negedge clk);
		hold = 1'b0;
	end

	always @(posedge clk) begin
		if (out_ch.valid && out_ch.ready)
			stream_model.check_byte(out_ch.out_byte, out_ch.last_of_item, out_ch.frame_end);
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("simulation failed");
		$finish;
	end

	initial begin
		logic       act;
		logic [7:0] id;
		logic [15:0] word;

		in_ch.valid     = 1'b0;
		in_ch.action    = ACT_VALUE;
		in_ch.value_id  = 8'h00;
		in_ch.data_word = 16'h0000;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_item(ACT_STOP, 8'h00, 16'h0000);
		send_item(ACT_VALUE, 8'h00, 16'h0000);
		send_item(ACT_VALUE, 8'hFF, 16'hFFFF);
		send_item(ACT_VALUE, HDR_BYTE, 16'h1234);
		send_item(ACT_VALUE, ESC_BYTE, 16'h4321);
		send_item(ACT_VALUE, 8'h01, {8'h00, HDR_BYTE});
		send_item(ACT_VALUE, 8'h02, {8'h00, ESC_BYTE});
		send_item(ACT_VALUE, 8'h03, {HDR_BYTE, 8'h00});
		send_item(ACT_VALUE, 8'h04, {ESC_BYTE, 8'h00});
		send_item(ACT_VALUE, 8'h05, {HDR_BYTE, HDR_BYTE});
		send_item(ACT_VALUE, 8'h06, {ESC_BYTE, ESC_BYTE});
		send_item(ACT_VALUE, 8'h07, {HDR_BYTE, ESC_BYTE});
		send_item(ACT_VALUE, HDR_BYTE, {ESC_BYTE, HDR_BYTE});
		send_item(ACT_VALUE, 8'h80, {8'h3E, 8'h3D});
		send_item(ACT_VALUE, 8'h7F, {8'h5F, 8'h5C});
		send_item(ACT_STOP, 8'hFF, 16'hFFFF);
		send_item(ACT_STOP, HDR_BYTE, {HDR_BYTE, ESC_BYTE});
		send_item(ACT_VALUE, 8'hAA, 16'h55AA);
		send_item(ACT_VALUE, 8'h55, 16'hAA55);
		send_item(ACT_STOP, 8'h00, 16'h0000);

		repeat (RANDOM_ITEMS) begin
			act  = ($urandom_range(0, 4) == 0) ? ACT_STOP : ACT_VALUE;
			id   = ($urandom_range(0, 1) == 0) ? pick_byte() : 8'($urandom_range(0, 255));
			word = ($urandom_range(0, 1) == 0) ? {pick_byte(), pick_byte()}
				: 16'($urandom_range(0, 65535));
			send_item(act, id, word);
		end
		@(negedge clk);
		in_ch.valid = 1'b0;

		while (stream_model.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		if (stream_model.mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
